### rtl/epv_pkg.sv
// Shared widths, types and pipeline depths for the edge-to-prism-vertices block.
package epv_pkg;

    localparam int COORD_W  = 32;           // endpoint / vertex coordinate width
    localparam int RAD_W    = 24;           // tube radius register width
    localparam int DIFF_W   = COORD_W + 1;  // raw edge vector
    localparam int D_W      = 31;           // reduced edge vector, |d| < 2^30
    localparam int V_W      = 64;           // vector entering a normalizer
    localparam int U_W      = 32;           // unit component, Q2.30
    localparam int Q30      = 30;

    // normalizer iteration split
    localparam int SQ_ITER  = 32;
    localparam int SQ_PER   = 2;
    localparam int SQ_ST    = SQ_ITER / SQ_PER;
    localparam int DIV_ITER = 32;
    localparam int DIV_PER  = 4;
    localparam int DIV_ST   = DIV_ITER / DIV_PER;

    // front end (5) + root stages + divide setup + divide stages + sign stage
    localparam int NORM_LAT = 5 + SQ_ST + 1 + DIV_ST + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [D_W-1:0]     dvec_t;
    typedef logic signed [V_W-1:0]     vwide_t;
    typedef logic signed [U_W-1:0]     unit_t;

endpackage

### rtl/epv_norm.sv
// Pipelined 3-vector normalizer: block shift, sum of squares, root, three dividers.
module epv_norm (
    input  logic            aclk,
    input  logic            en,
    input  epv_pkg::vwide_t v_in [3],
    output epv_pkg::unit_t  u_out [3],
    output logic            zero_out
);

    localparam int V_W    = epv_pkg::V_W;
    localparam int LEAD_W = $clog2(V_W);
    localparam int SH_W   = 32;
    localparam int M_W    = epv_pkg::Q30;
    localparam int SQR_W  = 2 * M_W;
    localparam int SS_W   = SQR_W + 2;
    localparam int SQ_W   = 64;
    localparam int N_W    = 31;
    localparam int NUM_W  = SS_W;
    localparam int Q_W    = 32;
    localparam int REM_W  = 32;
    localparam int SQ_ST  = epv_pkg::SQ_ST;
    localparam int SQ_PER = epv_pkg::SQ_PER;
    localparam int SQ_IT  = epv_pkg::SQ_ITER;
    localparam int DV_ST  = epv_pkg::DIV_ST;
    localparam int DV_PER = epv_pkg::DIV_PER;
    localparam int DV_IT  = epv_pkg::DIV_ITER;
    localparam int U_W    = epv_pkg::U_W;

    // stage 1: magnitude OR and leading bit
    logic [V_W-1:0]    mag_in [3];
    logic [V_W-1:0]    or_mag;
    logic [LEAD_W-1:0] lead;
    epv_pkg::vwide_t   v1_reg [3];
    logic [LEAD_W-1:0] lead1_reg;
    logic              zero1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = v_in[i][V_W-1] ? (~v_in[i] + V_W'(1)) : v_in[i];
        end
        or_mag = mag_in[0] | mag_in[1] | mag_in[2];
        lead   = '0;
        for (int b = 0; b < V_W; b++) begin
            if (or_mag[b]) lead = LEAD_W'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg    <= v_in;
            lead1_reg <= lead;
            zero1_reg <= (or_mag == '0);
        end
    end

    // stage 2: coarse shift putting the leading bit at 29
    epv_pkg::vwide_t          sh2 [3];
    logic signed [SH_W-1:0]   v2_reg [3];
    logic                     zero2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (lead1_reg >= LEAD_W'(M_W))
                sh2[i] = v1_reg[i] >>> (lead1_reg - LEAD_W'(M_W - 1));
            else
                sh2[i] = v1_reg[i] <<< (LEAD_W'(M_W - 1) - lead1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) v2_reg[i] <= sh2[i][SH_W-1:0];
            zero2_reg <= zero1_reg;
        end
    end

    // stage 3: floor shifts of negatives can land exactly on 2^30, take one more
    logic [SH_W-1:0]        mg2 [3];
    logic                   big2;
    logic signed [SH_W-1:0] v3 [3];
    logic [SH_W-1:0]        mg3 [3];
    logic [M_W-1:0]         m3_reg [3];
    logic [2:0]             sg3_reg;
    logic                   zero3_reg;

    always_comb begin
        big2 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mg2[i] = v2_reg[i][SH_W-1] ? (~v2_reg[i] + SH_W'(1)) : v2_reg[i];
            if (mg2[i][SH_W-1:M_W] != '0) big2 = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            v3[i]  = big2 ? (v2_reg[i] >>> 1) : v2_reg[i];
            mg3[i] = v3[i][SH_W-1] ? (~v3[i] + SH_W'(1)) : v3[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m3_reg[i]  <= mg3[i][M_W-1:0];
                sg3_reg[i] <= v3[i][SH_W-1];
            end
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: squares
    logic [SQR_W-1:0] sq4_reg [3];
    logic [M_W-1:0]   m4_reg [3];
    logic [2:0]       sg4_reg;
    logic             zero4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) sq4_reg[i] <= m3_reg[i] * m3_reg[i];
            m4_reg    <= m3_reg;
            sg4_reg   <= sg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5 feeds root stage 0; root stages follow
    logic [SQ_W-1:0] sx_reg [SQ_ST+1];
    logic [SQ_W-1:0] sr_reg [SQ_ST+1];
    logic [M_W-1:0]  sm_reg [SQ_ST+1][3];
    logic [2:0]      ssg_reg [SQ_ST+1];
    logic            sz_reg [SQ_ST+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg[0]  <= SQ_W'(SS_W'(sq4_reg[0]) + SS_W'(sq4_reg[1]) + SS_W'(sq4_reg[2]));
            sr_reg[0]  <= '0;
            sm_reg[0]  <= m4_reg;
            ssg_reg[0] <= sg4_reg;
            sz_reg[0]  <= zero4_reg;
        end
    end

    for (genvar s = 0; s < SQ_ST; s++) begin : g_root
        logic [SQ_W-1:0] x_c, r_c;

        always_comb begin
            logic [SQ_W-1:0] tb;
            tb  = '0;
            x_c = sx_reg[s];
            r_c = sr_reg[s];
            for (int t = 0; t < SQ_PER; t++) begin
                tb = SQ_W'(1) << (2 * (SQ_IT - 1 - (s * SQ_PER + t)));
                if (x_c >= r_c + tb) begin
                    x_c = x_c - (r_c + tb);
                    r_c = (r_c >> 1) + tb;
                end else begin
                    r_c = r_c >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[s+1]  <= x_c;
                sr_reg[s+1]  <= r_c;
                sm_reg[s+1]  <= sm_reg[s];
                ssg_reg[s+1] <= ssg_reg[s];
                sz_reg[s+1]  <= sz_reg[s];
            end
        end
    end

    // divide setup: numerator = m * 2^30 + n/2
    logic [N_W-1:0]   nroot;
    logic [NUM_W-1:0] num [3];
    logic [REM_W-1:0] dr_reg [DV_ST+1][3];
    logic [Q_W-1:0]   dl_reg [DV_ST+1][3];
    logic [Q_W-1:0]   dq_reg [DV_ST+1][3];
    logic [N_W-1:0]   dn_reg [DV_ST+1];
    logic [2:0]       dsg_reg [DV_ST+1];
    logic             dz_reg [DV_ST+1];

    assign nroot = sr_reg[SQ_ST][N_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = NUM_W'({sm_reg[SQ_ST][i], {M_W{1'b0}}}) + NUM_W'(nroot >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= REM_W'(num[i][NUM_W-1:Q_W]);
                dl_reg[0][i] <= num[i][Q_W-1:0];
                dq_reg[0][i] <= '0;
            end
            dn_reg[0]  <= nroot;
            dsg_reg[0] <= ssg_reg[SQ_ST];
            dz_reg[0]  <= sz_reg[SQ_ST];
        end
    end

    for (genvar s = 0; s < DV_ST; s++) begin : g_div
        logic [REM_W-1:0] r_c [3];
        logic [Q_W-1:0]   q_c [3];

        always_comb begin
            logic [REM_W-1:0] tr;
            int               bi;
            tr = '0;
            bi = 0;
            for (int i = 0; i < 3; i++) begin
                r_c[i] = dr_reg[s][i];
                q_c[i] = dq_reg[s][i];
                for (int t = 0; t < DV_PER; t++) begin
                    bi = DV_IT - 1 - (s * DV_PER + t);
                    tr = {r_c[i][REM_W-2:0], dl_reg[s][i][bi]};
                    if (tr >= REM_W'(dn_reg[s])) begin
                        r_c[i]     = tr - REM_W'(dn_reg[s]);
                        q_c[i][bi] = 1'b1;
                    end else begin
                        r_c[i] = tr;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dr_reg[s+1]  <= r_c;
                dq_reg[s+1]  <= q_c;
                dl_reg[s+1]  <= dl_reg[s];
                dn_reg[s+1]  <= dn_reg[s];
                dsg_reg[s+1] <= dsg_reg[s];
                dz_reg[s+1]  <= dz_reg[s];
            end
        end
    end

    // sign restore
    epv_pkg::unit_t u_reg [3];
    logic           zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= dsg_reg[DV_ST][i] ? -U_W'(dq_reg[DV_ST][i])
                                              : U_W'(dq_reg[DV_ST][i]);
            end
            zero_reg <= dz_reg[DV_ST];
        end
    end

    assign u_out    = u_reg;
    assign zero_out = zero_reg;

endmodule

### rtl/edge_to_prism_vertices_core.sv
// Top level: edge in, six triangular-prism vertices out, radius register on APB.
//
// One edge item (start and end point, signed Q16.16) yields six vertex items:
// corners 0..2 sit around the start point at 0/120/240 degrees, 3..5 around the
// end point, last marks corner 5. The block takes one edge for every six vertices
// it emits; that rate is set by the single result port, which emits one vertex per
// cycle while m_ready does not stall it. Internally the path is a fully pipelined
// chain (edge vector, cross with the fixed reference, normalizer, second cross,
// normalizer, 120/240 degree directions, radius offsets) that could accept an
// edge every cycle; the six-vertex serializer at the end throttles it. An edge
// of zero length or parallel to the reference gives its endpoints unchanged
// with degenerate set. tube_radius (24 bits, unsigned, reset 66) is at byte
// address 0; write it only while the block is empty.
module edge_to_prism_vertices_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  epv_pkg::coord_t       s_start_x,
    input  epv_pkg::coord_t       s_start_y,
    input  epv_pkg::coord_t       s_start_z,
    input  epv_pkg::coord_t       s_end_x,
    input  epv_pkg::coord_t       s_end_y,
    input  epv_pkg::coord_t       s_end_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output epv_pkg::coord_t       m_vertex_x,
    output epv_pkg::coord_t       m_vertex_y,
    output epv_pkg::coord_t       m_vertex_z,
    output logic [2:0]            m_corner,
    output logic                  m_last,
    output logic                  m_degenerate,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW      = epv_pkg::COORD_W;
    localparam int DIFF_W  = epv_pkg::DIFF_W;
    localparam int D_W     = epv_pkg::D_W;
    localparam int V_W     = epv_pkg::V_W;
    localparam int U_W     = epv_pkg::U_W;
    localparam int RAD_W   = epv_pkg::RAD_W;
    localparam int LAT     = epv_pkg::NORM_LAT;
    localparam int Q30     = epv_pkg::Q30;
    localparam int CRS_W   = D_W + U_W;        // d x u0 products
    localparam int BS_W    = U_W + Q30 + 1;    // base / side terms
    localparam int DIR_W   = 33;
    localparam int PRD_W   = RAD_W + 1 + DIR_W;
    localparam int OFF_W   = 30;

    localparam logic              REG_TUBE_RADIUS = 1'b0;
    localparam logic [RAD_W-1:0]  RAD_RESET       = RAD_W'(66);
    localparam logic [2:0]        CORNER_LAST     = 3'd5;
    localparam logic [2:0]        CORNER_END0     = 3'd3;

    localparam epv_pkg::vwide_t   REF_X = 64'sd1234;
    localparam epv_pkg::vwide_t   REF_Y = 64'sd5678;
    localparam epv_pkg::vwide_t   REF_Z = 64'sd9101;
    localparam logic signed [31:0] SQRT3_HALF = 32'sd929887697;
    localparam logic signed [V_W-1:0] HALF_Q30 = V_W'(1) <<< (Q30 - 1);

    // ---------------- configuration ----------------
    logic [RAD_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RAD_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TUBE_RADIUS) begin
            radius_reg <= pwdata[RAD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TUBE_RADIUS) ? 32'(radius_reg) : '0;

    // ---------------- flow control ----------------
    // One enable for every stage; it drops only while the serializer holds an
    // edge whose vertices are not all out.
    logic       adv;
    logic       out_load;
    logic [2:0] k_reg;
    logic       v8_reg;
    logic       m_valid_reg;

    assign out_load = v8_reg && (!m_valid_reg || m_ready);
    assign adv      = !v8_reg || (out_load && k_reg == CORNER_LAST);
    assign s_ready  = adv;

    // ---------------- T1: capture ----------------
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    epv_pkg::coord_t ep1_reg [2][3];
    epv_pkg::coord_t ep2_reg [2][3];
    epv_pkg::coord_t ep3_reg [2][3];
    epv_pkg::coord_t ep4_reg [2][3];
    logic signed [DIFF_W-1:0] d2_reg [3];
    epv_pkg::dvec_t  d3_reg [3];
    epv_pkg::dvec_t  d4_reg [3];
    epv_pkg::vwide_t c4_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // T3: smallest floor shift (0..3) bringing every component below 2^30
    logic signed [DIFF_W-1:0] dsh [4][3];
    logic [3:0]               dfit;
    epv_pkg::dvec_t           d3_next [3];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            dfit[n] = 1'b1;
            for (int i = 0; i < 3; i++) begin
                dsh[n][i] = d2_reg[i] >>> n;
                if (dsh[n][i] >= (DIFF_W'(1) <<< Q30) ||
                    dsh[n][i] <= -(DIFF_W'(1) <<< Q30)) dfit[n] = 1'b0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (dfit[0])      d3_next[i] = dsh[0][i][D_W-1:0];
            else if (dfit[1]) d3_next[i] = dsh[1][i][D_W-1:0];
            else if (dfit[2]) d3_next[i] = dsh[2][i][D_W-1:0];
            else              d3_next[i] = dsh[3][i][D_W-1:0];
        end
    end

    // T4: c = d x r
    epv_pkg::vwide_t dw [3];
    epv_pkg::vwide_t c4_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) dw[i] = V_W'(d3_reg[i]);
        c4_next[0] = dw[1] * REF_Z - dw[2] * REF_Y;
        c4_next[1] = dw[2] * REF_X - dw[0] * REF_Z;
        c4_next[2] = dw[0] * REF_Y - dw[1] * REF_X;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ep1_reg[0][0] <= s_start_x;
            ep1_reg[0][1] <= s_start_y;
            ep1_reg[0][2] <= s_start_z;
            ep1_reg[1][0] <= s_end_x;
            ep1_reg[1][1] <= s_end_y;
            ep1_reg[1][2] <= s_end_z;
            for (int i = 0; i < 3; i++) begin
                d2_reg[i] <= DIFF_W'(ep1_reg[1][i]) - DIFF_W'(ep1_reg[0][i]);
            end
            ep2_reg <= ep1_reg;
            d3_reg  <= d3_next;
            ep3_reg <= ep2_reg;
            c4_reg  <= c4_next;
            d4_reg  <= d3_reg;
            ep4_reg <= ep3_reg;
        end
    end

    // ---------------- first normal ----------------
    epv_pkg::unit_t u0 [3];
    logic           z1;

    epv_norm u_norm0 (
        .aclk     (aclk),
        .en       (adv),
        .v_in     (c4_reg),
        .u_out    (u0),
        .zero_out (z1)
    );

    logic            dl1_v_reg  [LAT];
    epv_pkg::coord_t dl1_ep_reg [LAT][2][3];
    epv_pkg::dvec_t  dl1_d_reg  [LAT][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) dl1_v_reg[k] <= 1'b0;
        end else if (adv) begin
            dl1_v_reg[0] <= v4_reg;
            for (int k = 1; k < LAT; k++) dl1_v_reg[k] <= dl1_v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl1_ep_reg[0] <= ep4_reg;
            dl1_d_reg[0]  <= d4_reg;
            for (int k = 1; k < LAT; k++) begin
                dl1_ep_reg[k] <= dl1_ep_reg[k-1];
                dl1_d_reg[k]  <= dl1_d_reg[k-1];
            end
        end
    end

    // T5: w = d x u0
    logic                     v5_reg;
    epv_pkg::vwide_t          w5_reg [3];
    epv_pkg::unit_t           u05_reg [3];
    epv_pkg::coord_t          ep5_reg [2][3];
    logic                     dg5_reg;
    logic signed [CRS_W-1:0]  pa [3];
    logic signed [CRS_W-1:0]  pb [3];
    epv_pkg::dvec_t           dd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) dd[i] = dl1_d_reg[LAT-1][i];
        pa[0] = dd[1] * u0[2];
        pb[0] = dd[2] * u0[1];
        pa[1] = dd[2] * u0[0];
        pb[1] = dd[0] * u0[2];
        pa[2] = dd[0] * u0[1];
        pb[2] = dd[1] * u0[0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) w5_reg[i] <= V_W'(pa[i]) - V_W'(pb[i]);
            u05_reg <= u0;
            ep5_reg <= dl1_ep_reg[LAT-1];
            dg5_reg <= z1;
        end
    end

    // ---------------- second normal ----------------
    epv_pkg::unit_t u90 [3];
    logic           z2;

    epv_norm u_norm90 (
        .aclk     (aclk),
        .en       (adv),
        .v_in     (w5_reg),
        .u_out    (u90),
        .zero_out (z2)
    );

    logic            dl2_v_reg  [LAT];
    epv_pkg::coord_t dl2_ep_reg [LAT][2][3];
    epv_pkg::unit_t  dl2_u_reg  [LAT][3];
    logic            dl2_dg_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            for (int k = 0; k < LAT; k++) dl2_v_reg[k] <= 1'b0;
        end else if (adv) begin
            v5_reg       <= dl1_v_reg[LAT-1];
            dl2_v_reg[0] <= v5_reg;
            for (int k = 1; k < LAT; k++) dl2_v_reg[k] <= dl2_v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl2_ep_reg[0] <= ep5_reg;
            dl2_u_reg[0]  <= u05_reg;
            dl2_dg_reg[0] <= dg5_reg;
            for (int k = 1; k < LAT; k++) begin
                dl2_ep_reg[k] <= dl2_ep_reg[k-1];
                dl2_u_reg[k]  <= dl2_u_reg[k-1];
                dl2_dg_reg[k] <= dl2_dg_reg[k-1];
            end
        end
    end

    // T6: base = -u0/2, side = u90*sqrt(3)/2, both at scale 2^60
    logic                   v6_reg, v7_reg;
    logic signed [BS_W-1:0] base6_reg [3];
    logic signed [BS_W-1:0] side6_reg [3];
    epv_pkg::unit_t         u06_reg [3];
    epv_pkg::coord_t        ep6_reg [2][3];
    logic                   dg6_reg;

    // T7: directions
    logic signed [DIR_W-1:0] dir7_reg [3][3];
    epv_pkg::coord_t         ep7_reg [2][3];
    logic                    dg7_reg;
    epv_pkg::vwide_t         sum_p [3];
    epv_pkg::vwide_t         sum_m [3];
    epv_pkg::vwide_t         shp [3];
    epv_pkg::vwide_t         shm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum_p[i] = V_W'(base6_reg[i]) + V_W'(side6_reg[i]) + HALF_Q30;
            sum_m[i] = V_W'(base6_reg[i]) - V_W'(side6_reg[i]) + HALF_Q30;
            shp[i]   = sum_p[i] >>> Q30;
            shm[i]   = sum_m[i] >>> Q30;
        end
    end

    // T8: offsets, radius * direction rounded back to coordinate format
    logic signed [PRD_W-1:0]  prod [3][3];
    logic signed [PRD_W-1:0]  prnd [3][3];
    logic signed [RAD_W:0]    rad_s;
    logic signed [OFF_W-1:0]  off8_reg [3][3];
    epv_pkg::coord_t          ep8_reg [2][3];
    logic                     dg8_reg;

    assign rad_s = $signed({1'b0, radius_reg});

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
                prod[a][i] = rad_s * dir7_reg[a][i];
                prnd[a][i] = (prod[a][i] + PRD_W'(HALF_Q30)) >>> Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= dl2_v_reg[LAT-1];
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                base6_reg[i] <= -(BS_W'(dl2_u_reg[LAT-1][i]) <<< (Q30 - 1));
                side6_reg[i] <= BS_W'(u90[i]) * BS_W'(SQRT3_HALF);
            end
            u06_reg <= dl2_u_reg[LAT-1];
            ep6_reg <= dl2_ep_reg[LAT-1];
            dg6_reg <= dl2_dg_reg[LAT-1] | z2;

            for (int i = 0; i < 3; i++) begin
                dir7_reg[0][i] <= DIR_W'(u06_reg[i]);
                dir7_reg[1][i] <= shp[i][DIR_W-1:0];
                dir7_reg[2][i] <= shm[i][DIR_W-1:0];
            end
            ep7_reg <= ep6_reg;
            dg7_reg <= dg6_reg;

            // degenerate edges keep their endpoints: zero offset
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    off8_reg[a][i] <= dg7_reg ? '0 : prnd[a][i][OFF_W-1:0];
                end
            end
            ep8_reg <= ep7_reg;
            dg8_reg <= dg7_reg;
        end
    end

    // ---------------- six-vertex serializer ----------------
    logic                 end_sel;
    logic [1:0]           ang;
    logic signed [CW:0]   vsum [3];
    epv_pkg::coord_t      vsat [3];
    epv_pkg::coord_t      vx_reg, vy_reg, vz_reg;
    logic [2:0]           corner_reg;
    logic                 last_reg, degen_reg;

    always_comb begin
        end_sel = (k_reg >= CORNER_END0);
        ang     = end_sel ? 2'(k_reg - CORNER_END0) : k_reg[1:0];
        for (int i = 0; i < 3; i++) begin
            vsum[i] = (CW + 1)'(ep8_reg[end_sel][i]) + (CW + 1)'(off8_reg[ang][i]);
            if (vsum[i][CW] != vsum[i][CW-1])
                vsat[i] = vsum[i][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else
                vsat[i] = vsum[i][CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                k_reg       <= (k_reg == CORNER_LAST) ? '0 : k_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            vx_reg     <= vsat[0];
            vy_reg     <= vsat[1];
            vz_reg     <= vsat[2];
            corner_reg <= k_reg;
            last_reg   <= (k_reg == CORNER_LAST);
            degen_reg  <= dg8_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_vertex_x   = vx_reg;
    assign m_vertex_y   = vy_reg;
    assign m_vertex_z   = vz_reg;
    assign m_corner     = corner_reg;
    assign m_last       = last_reg;
    assign m_degenerate = degen_reg;

endmodule

### tb/tb_edge_to_prism_vertices_core.sv
// Testbench for edge_to_prism_vertices_core: edge items in, prism vertex items checked.
`timescale 1ns / 1ps

module tb_edge_to_prism_vertices_core;

    typedef epv_pkg::coord_t coord_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam logic [2:0] ADDR_TUBE_RADIUS = 3'd0;
    localparam longint SQRT3_HALF = 64'sd929887697;
    localparam longint HALF_ONE   = 64'sd1 << 29;
    localparam longint ONE_Q30    = 64'sd1 << 30;

    typedef struct packed {
        coord_t sx, sy, sz, ex, ey, ez;
    } edge_t;

    typedef struct packed {
        coord_t     x, y, z;
        logic [2:0] corner;
        logic       last;
        logic       degenerate;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_start_x = '0, s_start_y = '0, s_start_z = '0;
    coord_t s_end_x = '0, s_end_y = '0, s_end_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    coord_t m_vertex_x, m_vertex_y, m_vertex_z;
    logic [2:0] m_corner;
    logic m_last, m_degenerate;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    edge_t   pending_edges[$];
    vertex_t expected_vertices[$];
    logic [23:0] radius_model;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    always #10 aclk = ~aclk;

    edge_to_prism_vertices_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_start_z(s_start_z),
        .s_end_x(s_end_x), .s_end_y(s_end_y), .s_end_z(s_end_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vertex_x(m_vertex_x), .m_vertex_y(m_vertex_y), .m_vertex_z(m_vertex_z),
        .m_corner(m_corner), .m_last(m_last), .m_degenerate(m_degenerate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ---------------- prediction ----------------
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;     // arithmetic shift is a floor shift
    endfunction

    function automatic longint abs_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint largest_mag(longint v[3]);
        longint m;
        m = abs_of(v[0]);
        if (abs_of(v[1]) > m) m = abs_of(v[1]);
        if (abs_of(v[2]) > m) m = abs_of(v[2]);
        return m;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic void cross_of(longint a[3], longint b[3], output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Unit vector in Q2.30; returns 0 for a zero vector.
    function automatic bit unit_vector(longint vin[3], output longint u[3]);
        longint v[3];
        longint unsigned sumsq, norm, q, mg;
        v = vin;
        u = '{0, 0, 0};
        if (largest_mag(v) == 0) return 1'b0;
        while (largest_mag(v) >= ONE_Q30)
            foreach (v[i]) v[i] = floor_shr(v[i], 1);
        while (largest_mag(v) < HALF_ONE)
            foreach (v[i]) v[i] = v[i] * 2;
        sumsq = 0;
        foreach (v[i]) begin
            mg = abs_of(v[i]);
            sumsq += mg * mg;
        end
        norm = int_sqrt(sumsq);
        foreach (v[i]) begin
            mg = abs_of(v[i]);
            q = ((mg << 30) + norm / 2) / norm;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint round_q30(longint x);
        return floor_shr(x + HALF_ONE, 30);
    endfunction

    function automatic longint sat_coord(longint a, longint b);
        longint s;
        s = a + b;      // both well inside 64 bits
        if (s > 64'sd2147483647) return 64'sd2147483647;
        if (s < -64'sd2147483648) return -64'sd2147483648;
        return s;
    endfunction

    function automatic void predict_prism(edge_t e);
        longint pt[2][3];
        longint d[3], c[3], w[3], u0[3], u90[3];
        longint dirs[3][3];
        longint refdir[3];
        bit ok;
        vertex_t vx;
        longint v;
        refdir = '{1234, 5678, 9101};
        pt[0] = '{longint'(e.sx), longint'(e.sy), longint'(e.sz)};
        pt[1] = '{longint'(e.ex), longint'(e.ey), longint'(e.ez)};
        foreach (d[i]) d[i] = pt[1][i] - pt[0][i];
        while (largest_mag(d) >= ONE_Q30)
            foreach (d[i]) d[i] = floor_shr(d[i], 1);
        cross_of(d, refdir, c);
        ok = unit_vector(c, u0);
        if (ok) begin
            cross_of(d, u0, w);
            ok = unit_vector(w, u90);
        end
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                dirs[0][i] = u0[i];
                dirs[1][i] = round_q30(-u0[i] * HALF_ONE + u90[i] * SQRT3_HALF);
                dirs[2][i] = round_q30(-u0[i] * HALF_ONE - u90[i] * SQRT3_HALF);
            end
        end
        for (int k = 0; k < 6; k++) begin
            longint res[3];
            for (int i = 0; i < 3; i++) begin
                v = pt[k / 3][i];
                if (ok) v = sat_coord(v, round_q30(longint'(radius_model) * dirs[k % 3][i]));
                res[i] = v;
            end
            vx.x = coord_t'(res[0]);
            vx.y = coord_t'(res[1]);
            vx.z = coord_t'(res[2]);
            vx.corner = 3'(k);
            vx.last = (k == 5);
            vx.degenerate = !ok;
            expected_vertices.insert(expected_vertices.size(), vx);
        end
    endfunction

    // ---------------- driver ----------------
    // The prediction is made when an edge is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_prism({s_start_x, s_start_y, s_start_z, s_end_x, s_end_y, s_end_z});
            end
            if (!s_valid || s_ready) begin
                if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    edge_t e;
                    e = pending_edges.pop_front();
                    s_valid   <= 1'b1;
                    s_start_x <= e.sx;
                    s_start_y <= e.sy;
                    s_start_z <= e.sz;
                    s_end_x   <= e.ex;
                    s_end_y   <= e.ey;
                    s_end_z   <= e.ez;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t: vertex item with none expected: x=%h y=%h z=%h corner=%0d",
                             $time, m_vertex_x, m_vertex_y, m_vertex_z, m_corner);
                    fail_count++;
                end else begin
                    vertex_t exp_v;
                    exp_v = expected_vertices.pop_front();
                    if (m_vertex_x !== exp_v.x || m_vertex_y !== exp_v.y ||
                        m_vertex_z !== exp_v.z || m_corner !== exp_v.corner ||
                        m_last !== exp_v.last || m_degenerate !== exp_v.degenerate) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h c=%0d l=%b d=%b",
                                 $time, exp_v.x, exp_v.y, exp_v.z, exp_v.corner,
                                 exp_v.last, exp_v.degenerate);
                        $display("%0t:          actual   x=%h y=%h z=%h c=%0d l=%b d=%b",
                                 $time, m_vertex_x, m_vertex_y, m_vertex_z, m_corner,
                                 m_last, m_degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with nothing moving ends the run.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL edge_to_prism_vertices_core");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_radius(logic [23:0] radius);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TUBE_RADIUS;
        pwdata  <= {8'd0, radius};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radius_model = radius;
    endtask

    task automatic wait_drained();
        while (pending_edges.size() > 0 || s_valid || expected_vertices.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(3))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(2000)) - 1000;
            2: return coord_t'($urandom) >>> $urandom_range(31);
            default: return coord_t'($urandom) >>> 12;
        endcase
    endfunction

    function automatic void add_edge(coord_t sx, coord_t sy, coord_t sz,
                                     coord_t ex, coord_t ey, coord_t ez);
        pending_edges.insert(pending_edges.size(), {sx, sy, sz, ex, ey, ez});
    endfunction

    function automatic void add_random_edges(int count);
        coord_t sx, sy, sz;
        int f;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord();
            sy = rand_coord();
            sz = rand_coord();
            case ($urandom_range(9))
                0: add_edge(sx, sy, sz, sx, sy, sz);            // zero length
                1: begin                                         // along reference
                    f = $urandom_range(1, 50);
                    add_edge(sx, sy, sz, sx + 1234 * f, sy + 5678 * f, sz + 9101 * f);
                end
                2: add_edge(sx, sy, sz, sx + coord_t'($urandom_range(3)),
                            sy - coord_t'($urandom_range(3)), sz);  // tiny edge
                default: add_edge(sx, sy, sz, rand_coord(), rand_coord(), rand_coord());
            endcase
        end
    endfunction

    localparam coord_t CMAX = 32'sh7fffffff;
    localparam coord_t CMIN = 32'sh80000000;

    initial begin
        radius_model = 24'd66;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset radius, extremes, degenerate edges, saturation
        add_edge(0, 0, 0, 32'sh10000, 0, 0);
        add_edge(0, 0, 0, 0, 0, 0);
        add_edge(100, 200, 300, 100 + 1234, 200 + 5678, 300 + 9101);
        add_edge(-5, 7, 9, -5 - 2468, 7 - 11356, 9 - 18202);
        add_edge(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        add_edge(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        add_edge(CMAX, CMAX, CMAX, CMAX, CMAX - 1, CMAX);
        add_edge(0, 0, 0, 0, 0, 1);
        add_edge(32'shffffffff, 0, 0, 0, 32'shffffffff, 0);
        wait_drained();

        write_radius(24'hffffff);
        add_edge(CMAX, CMAX, CMAX, CMAX - 32'sh100000, CMAX, CMAX - 32'sh200000);
        add_edge(CMIN, CMIN, CMIN, CMIN + 32'sh100000, CMIN + 5, CMIN);
        add_edge(0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000);
        add_edge(1, 2, 3, 1, 2, 3);
        add_edge(CMAX, CMIN, 0, CMIN, CMAX, 0);
        add_edge(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
                 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
        wait_drained();

        write_radius(24'd0);
        add_edge(10, 20, 30, -40, 50, 60);
        add_edge(CMIN, CMAX, CMIN, 0, 0, 0);
        add_random_edges(15);
        wait_drained();

        // random: four idling phases over several radius settings
        write_radius(24'd66);
        send_idle_pct = 0;  recv_stall_pct = 0;
        add_random_edges(40);
        wait_drained();

        write_radius(24'($urandom));
        send_idle_pct = 80; recv_stall_pct = 0;
        add_random_edges(35);
        wait_drained();

        write_radius(24'h10000);
        send_idle_pct = 0;  recv_stall_pct = 80;
        add_random_edges(35);
        wait_drained();

        write_radius(24'($urandom_range(1, 24'hffffff)));
        send_idle_pct = 34; recv_stall_pct = 34;
        add_random_edges(28);
        wait_drained();

        if (fail_count == 0) begin
            $display("PASS edge_to_prism_vertices_core");
        end else begin
            $display("FAIL edge_to_prism_vertices_core");
        end
        $finish;
    end

endmodule

### sim.f
rtl/epv_pkg.sv
rtl/epv_norm.sv
rtl/edge_to_prism_vertices_core.sv
tb/tb_edge_to_prism_vertices_core.sv
